// ===== rtl/sequence_reorder_queue_macros.svh =====
// Assertion macros for the sequence reorder queue.
// Included by the RTL files that carry concurrent checks; no dependencies.
`ifndef SEQUENCE_REORDER_QUEUE_MACROS_SVH
`define SEQUENCE_REORDER_QUEUE_MACROS_SVH

// Condition implies consequence in the same cycle.
`define SRQ_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Condition implies consequence in the next cycle.
`define SRQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/srq_pkg.sv =====
// Shared types and codes for the sequence reorder queue.
// No dependencies; imported by srq_ctrl, srq_dp and the top level.
`default_nettype none

package srq_pkg;

    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] entry_seq;
        logic [31:0] entry_payload;
        logic [31:0] expected_seq;
    } t_in_word;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] out_seq;
        logic [31:0] out_payload;
        logic [6:0]  occupancy;
    } t_out_word;

    // operation codes
    localparam logic [1:0] OP_PUSH   = 2'd0;
    localparam logic [1:0] OP_POP    = 2'd1;
    localparam logic [1:0] OP_FINISH = 2'd2;

    // result status codes
    localparam logic [2:0] ST_PUSHED       = 3'd0;
    localparam logic [2:0] ST_POPPED       = 3'd1;
    localparam logic [2:0] ST_NOT_EXPECTED = 3'd2;
    localparam logic [2:0] ST_EMPTY_WAIT   = 3'd3;
    localparam logic [2:0] ST_DONE         = 3'd4;
    localparam logic [2:0] ST_FULL_DROP    = 3'd5;

    // read address select
    localparam logic [1:0] RD_HEAD  = 2'd0;
    localparam logic [1:0] RD_TAIL  = 2'd1;
    localparam logic [1:0] RD_BELOW = 2'd2;

    // write data select
    localparam logic WR_NEW  = 1'b0;
    localparam logic WR_MOVE = 1'b1;

    typedef struct packed {
        logic       latch_in;
        logic       rd_en;
        logic [1:0] rd_sel;
        logic       wr_en;
        logic       wr_sel;
        logic       k_load;
        logic       k_dec;
        logic       count_inc;
        logic       count_dec;
        logic       head_adv;
        logic       flag_set;
        logic       pend_load;
        logic [2:0] pend_status;
        logic       pend_take_data;
        logic       out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic empty;
        logic full;
        logic k_is_one;
        logic seq_ge;
        logic seq_eq;
        logic finished;
        logic out_free;
    } t_dp_sts;

endpackage

`default_nettype wire

// ===== rtl/srq_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none

module srq_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ===== rtl/srq_ctrl.sv =====
// Sequencer for the reorder queue: decodes operations, steps the sorted insert.
// Depends on srq_pkg.
`default_nettype none

module srq_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    input  wire logic [1:0]      i_op,
    input  wire srq_pkg::t_dp_sts i_sts,
    output srq_pkg::t_dp_cmd     o_cmd
);

    import srq_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_INS   = 3'd2;
    localparam logic [2:0] S_POPRD = 3'd3;
    localparam logic [2:0] S_RESP  = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;
    t_dp_cmd    cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        cmd     = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.latch_in = 1'b1;
                    unique case (i_op)
                        OP_PUSH: begin
                            if (i_sts.full) begin
                                cmd.pend_load   = 1'b1;
                                cmd.pend_status = ST_FULL_DROP;
                                n_state         = S_RESP;
                            end else begin
                                cmd.k_load = 1'b1;
                                if (i_sts.empty) begin
                                    n_state = S_INS;
                                end else begin
                                    cmd.rd_en  = 1'b1;
                                    cmd.rd_sel = RD_TAIL;
                                    n_state    = S_SCAN;
                                end
                            end
                        end
                        OP_POP: begin
                            if (i_sts.empty) begin
                                cmd.pend_load   = 1'b1;
                                cmd.pend_status = i_sts.finished ? ST_DONE : ST_EMPTY_WAIT;
                                n_state         = S_RESP;
                            end else begin
                                cmd.rd_en  = 1'b1;
                                cmd.rd_sel = RD_HEAD;
                                n_state    = S_POPRD;
                            end
                        end
                        OP_FINISH: begin
                            cmd.flag_set    = 1'b1;
                            cmd.pend_load   = 1'b1;
                            cmd.pend_status = ST_DONE;
                            n_state         = S_RESP;
                        end
                        default: begin
                            cmd.pend_load   = 1'b1;
                            cmd.pend_status = ST_EMPTY_WAIT;
                            n_state         = S_RESP;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (i_sts.seq_ge) begin
                    // stored entry moves up one slot
                    cmd.wr_en  = 1'b1;
                    cmd.wr_sel = WR_MOVE;
                    cmd.k_dec  = 1'b1;
                    if (i_sts.k_is_one) begin
                        n_state = S_INS;
                    end else begin
                        cmd.rd_en  = 1'b1;
                        cmd.rd_sel = RD_BELOW;
                    end
                end else begin
                    cmd.wr_en       = 1'b1;
                    cmd.wr_sel      = WR_NEW;
                    cmd.count_inc   = 1'b1;
                    cmd.pend_load   = 1'b1;
                    cmd.pend_status = ST_PUSHED;
                    n_state         = S_RESP;
                end
            end
            S_INS: begin
                cmd.wr_en       = 1'b1;
                cmd.wr_sel      = WR_NEW;
                cmd.count_inc   = 1'b1;
                cmd.pend_load   = 1'b1;
                cmd.pend_status = ST_PUSHED;
                n_state         = S_RESP;
            end
            S_POPRD: begin
                cmd.pend_load = 1'b1;
                if (i_sts.seq_eq) begin
                    cmd.pend_status    = ST_POPPED;
                    cmd.pend_take_data = 1'b1;
                    cmd.head_adv       = 1'b1;
                    cmd.count_dec      = 1'b1;
                end else begin
                    cmd.pend_status = ST_NOT_EXPECTED;
                end
                n_state = S_RESP;
            end
            S_RESP: begin
                if (i_sts.out_free) begin
                    cmd.out_load = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_cmd      = cmd;
    assign o_in_ready = (r_state == S_IDLE);

endmodule

`default_nettype wire

// ===== rtl/srq_dp.sv =====
// Datapath for the reorder queue: circular sorted store, counters, result registers.
// Depends on srq_pkg, srq_ram and sequence_reorder_queue_macros.svh.
`default_nettype none

module srq_dp #(
    parameter int DEPTH        = 64,
    parameter int PAYLOAD_BITS = 32
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire srq_pkg::t_in_word  i_in_word,
    input  wire srq_pkg::t_dp_cmd   i_cmd,
    output srq_pkg::t_dp_sts        o_sts,
    input  wire logic               i_out_ready,
    output logic                    o_out_valid,
    output srq_pkg::t_out_word      o_out_word
);

    import srq_pkg::*;

`include "sequence_reorder_queue_macros.svh"

    localparam int PB = (PAYLOAD_BITS < 32) ? PAYLOAD_BITS : 32;
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 1;
    localparam int DW = 32 + PB;

    logic [AW-1:0] r_head;
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_k;
    logic          r_finished;
    logic [31:0]   r_seq;
    logic [PB-1:0] r_pay;
    logic [31:0]   r_exp;
    logic [2:0]    r_pend_status;
    logic [31:0]   r_pend_seq;
    logic [PB-1:0] r_pend_pay;
    logic          r_out_valid;
    t_out_word     r_out_word;

    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic [DW-1:0] wr_data;
    logic [DW-1:0] rd_data;
    logic [31:0]   rd_seq;
    logic [PB-1:0] rd_pay;

    // logical position behind the head -> physical slot
    function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                           input logic [CW-1:0] pos);
        logic [SW-1:0] s;
        s = SW'(head) + SW'(pos);
        if (s >= SW'(DEPTH)) begin
            s = s - SW'(DEPTH);
        end
        return AW'(s);
    endfunction

    assign rd_seq = rd_data[DW-1 -: 32];
    assign rd_pay = rd_data[PB-1:0];

    always_comb begin
        case (i_cmd.rd_sel)
            RD_TAIL:  rd_addr = phys(r_head, r_count - CW'(1));
            RD_BELOW: rd_addr = phys(r_head, r_k - CW'(2));
            default:  rd_addr = r_head;
        endcase
    end

    assign wr_addr = phys(r_head, r_k);
    assign wr_data = (i_cmd.wr_sel == WR_MOVE) ? rd_data : {r_seq, r_pay};

    srq_ram #(
        .WIDTH (DW),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (i_cmd.rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_count     <= '0;
            r_finished  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.head_adv) begin
                r_head <= (r_head == AW'(DEPTH - 1)) ? '0 : r_head + AW'(1);
            end
            if (i_cmd.count_inc) begin
                r_count <= r_count + CW'(1);
            end else if (i_cmd.count_dec) begin
                r_count <= r_count - CW'(1);
            end
            if (i_cmd.flag_set) begin
                r_finished <= 1'b1;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_seq <= i_in_word.entry_seq;
            r_pay <= PB'(i_in_word.entry_payload);
            r_exp <= i_in_word.expected_seq;
        end
        if (i_cmd.k_load) begin
            r_k <= r_count;
        end else if (i_cmd.k_dec) begin
            r_k <= r_k - CW'(1);
        end
        if (i_cmd.pend_load) begin
            r_pend_status <= i_cmd.pend_status;
            r_pend_seq    <= i_cmd.pend_take_data ? rd_seq : '0;
            r_pend_pay    <= i_cmd.pend_take_data ? rd_pay : '0;
        end
        if (i_cmd.out_load) begin
            r_out_word.status      <= r_pend_status;
            r_out_word.out_seq     <= r_pend_seq;
            r_out_word.out_payload <= 32'(r_pend_pay);
            r_out_word.occupancy   <= 7'(r_count);
        end
    end

    assign o_sts.empty    = (r_count == '0);
    assign o_sts.full     = (r_count == CW'(DEPTH));
    assign o_sts.k_is_one = (r_k == CW'(1));
    assign o_sts.seq_ge   = (rd_seq >= r_seq);
    assign o_sts.seq_eq   = (rd_seq == r_exp);
    assign o_sts.finished = r_finished;
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    `SRQ_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(DEPTH), "count above depth")
    `SRQ_ASSERT_NOW(a_no_insert_full, i_clk, i_rst_n, i_cmd.count_inc, r_count < CW'(DEPTH), "insert into full store")
    `SRQ_ASSERT_NEXT(a_pop_shrinks, i_clk, i_rst_n, i_cmd.head_adv, r_count == $past(r_count) - CW'(1), "pop did not shrink store")

endmodule

`default_nettype wire

// ===== rtl/sequence_reorder_queue.sv =====
// Top level of the sequence reorder queue: sequencer plus datapath.
// Depends on srq_pkg, srq_ctrl, srq_dp (and through it srq_ram).
`default_nettype none

// Channel  Direction  Handshake                 Word
// input    in         i_in_valid / o_in_ready   srq_pkg::t_in_word
// output   out        o_out_valid / i_out_ready srq_pkg::t_out_word
//
// Push: the scan state moves every stored entry with a sequence number equal to or
//   above the new one up a slot, then the new word is written; the single RAM port pair moves one entry a cycle.
// Pop of a stored entry passes through a read state (registered RAM read of the head); an empty pop,
//   finish, unused code or dropped push go straight from idle to the response state.
// Reset (synchronous, active low) clears count, head, finish flag and the output
//   valid flag; the store itself needs no clearing, only slots below count are read.
// A result held in the output register does not block the next input word; only a
//   second result waiting behind it stalls the sequencer in its response state.

module sequence_reorder_queue #(
    parameter int DEPTH        = 64,
    parameter int PAYLOAD_BITS = 32
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire srq_pkg::t_in_word  i_in_word,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output srq_pkg::t_out_word      o_out_word
);

    import srq_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    // sequencer: owns the accept decision and the insert / pop stepping
    srq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_op       (i_in_word.operation),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // datapath: circular sorted store, counters, pending and output words
    srq_dp #(
        .DEPTH        (DEPTH),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_word   (i_in_word),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word)
    );

endmodule

`default_nettype wire
